FILE: src/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Piece table text store package
// Shared field widths, action codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 14;
   localparam int CNT_W  = 7;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_INSERT = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 3'd0,
      ST_TABLE_FULL  = 3'd1,
      ST_STORE_FULL  = 3'd2,
      ST_RANGE       = 3'd3,
      ST_LOAD_DENIED = 3'd4
   } status_type;

endpackage

`default_nettype wire

FILE: src/ptts_req_if.sv
// ----------------------------------------------------------------------------
// Piece table text store request channel
// Valid/ready channel that carries one editing or read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptts_req_if;
   import ptts_pkg::*;

   logic              valid;
   logic              ready;
   action_type        action;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_run;
   logic [POS_W-1:0]  slice_pos;
   logic [CNT_W-1:0]  read_count;

   modport source (output valid, action, data_byte, end_of_run, slice_pos, read_count,
                   input ready);
   modport sink   (input valid, action, data_byte, end_of_run, slice_pos, read_count,
                   output ready);
endinterface

`default_nettype wire

FILE: src/ptts_rsp_if.sv
// ----------------------------------------------------------------------------
// Piece table text store response channel
// Valid/ready channel that carries one result of a request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptts_rsp_if;
   import ptts_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   status_type        status;
   logic [POS_W-1:0]  cursor_pos;
   logic [POS_W-1:0]  doc_length;

   modport source (output valid, out_byte, last, status, cursor_pos, doc_length,
                   input ready);
   modport sink   (input valid, out_byte, last, status, cursor_pos, doc_length,
                   output ready);
endinterface

`default_nettype wire

FILE: src/ptts_ram.sv
// ----------------------------------------------------------------------------
// Piece table text store RAM
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/piece_table_text_store_unit.sv
// ----------------------------------------------------------------------------
// Piece table text store unit
// Clear, load and a plain insert byte go straight to the response.
// A closing insert reads and checks each piece in turn, shifts the tail by reading
// and writing each entry, and writes up to 3 entries into the piece table.
// A read walks to its start piece, then reads, registers and emits each byte,
// walking on at each piece crossed; one request at a time through one table port.
// Synchronous reset empties the document; the stores themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module piece_table_text_store_unit #(
   parameter int MAX_PIECES = 64,
   parameter int ADD_BYTES  = 4096,
   parameter int ORIG_BYTES = 4096,
   parameter int MAX_SLICE  = 64
) (
   input wire logic clock,
   input wire logic reset,
   ptts_req_if.sink   req_ch,
   ptts_rsp_if.source rsp_ch
);
   import ptts_pkg::*;

   localparam int PI_W   = $clog2(MAX_PIECES);
   localparam int PC_W   = $clog2(MAX_PIECES + 1);
   localparam int AA_W   = $clog2(ADD_BYTES);
   localparam int AU_W   = $clog2(ADD_BYTES + 1);
   localparam int OA_W   = $clog2(ORIG_BYTES);
   localparam int OS_W   = $clog2(ORIG_BYTES + 1);
   localparam int MAXB   = (ADD_BYTES > ORIG_BYTES) ? ADD_BYTES : ORIG_BYTES;
   localparam int OFF_W  = (AA_W > OA_W) ? AA_W : OA_W;
   localparam int LEN_W  = $clog2(MAXB + 1);
   localparam int TOT_W  = $clog2(ORIG_BYTES + ADD_BYTES + 1);
   localparam int CW     = (TOT_W > POS_W) ? TOT_W : POS_W;
   localparam int PE_W   = 1 + OFF_W + LEN_W;

   typedef enum logic [3:0] {
      S_IDLE, S_RESP, S_SP_RD, S_SP_CHK, S_SP_APP, S_SH_RD, S_SH_WR, S_PUT,
      S_RD_FIND, S_RD_FCHK, S_RD_BYTE, S_RD_WAIT, S_RD_EMIT
   } state_type;

   state_type         state_ff;
   logic [PC_W-1:0]   piece_count_ff;
   logic [AU_W-1:0]   add_used_ff;
   logic [OS_W-1:0]   orig_size_ff;
   logic [CW-1:0]     total_ff;
   logic [CW-1:0]     cursor_ff;
   logic [AA_W-1:0]   run_start_ff;
   logic [AU_W-1:0]   run_len_ff;
   logic              edited_ff;

   logic [PC_W-1:0]   i_ff;
   logic [PC_W-1:0]   j_ff;
   logic [CW-1:0]     cur_ff;
   logic [CW-1:0]     pos_ff;
   logic [PI_W-1:0]   idx_ff;
   logic [PI_W-1:0]   wp_ff;
   logic [1:0]        phase_ff;
   logic [1:0]        net_ff;
   logic              hsrc_ff;
   logic [OFF_W-1:0]  hoff_ff;
   logic [LEN_W-1:0]  hlen_ff;
   logic [LEN_W-1:0]  in_off_ff;
   logic [CNT_W-1:0]  remain_ff;

   logic [BYTE_W-1:0] out_byte_ff;
   logic              last_ff;
   status_type        status_ff;

   logic              p_we;
   logic [PI_W-1:0]   p_wa;
   logic [PE_W-1:0]   p_wd;
   logic [PI_W-1:0]   p_ra;
   logic [PE_W-1:0]   p_rd;
   logic              a_we;
   logic [AA_W-1:0]   a_ra;
   logic [BYTE_W-1:0] a_rd;
   logic              o_we;
   logic [OA_W-1:0]   o_ra;
   logic [BYTE_W-1:0] o_rd;

   logic              accept;
   logic              pr_src;
   logic [OFF_W-1:0]  pr_off;
   logic [LEN_W-1:0]  pr_len;
   logic [CW-1:0]     pr_next;
   logic [CW-1:0]     cur_off;
   logic [CW-1:0]     start_ext;
   logic [CW-1:0]     avail;
   logic [CW-1:0]     want;
   logic [OFF_W-1:0]  byte_addr;
   logic              add_full;
   logic [AU_W-1:0]   rl_new;
   logic [1:0]        net_new;
   logic [PC_W:0]     need;
   logic [CW-1:0]     run_ext;

   assign accept    = req_ch.valid && req_ch.ready;
   assign pr_src    = p_rd[PE_W-1];
   assign pr_off    = p_rd[OFF_W+LEN_W-1:LEN_W];
   assign pr_len    = p_rd[LEN_W-1:0];
   assign pr_next   = cur_ff + CW'(pr_len);
   assign start_ext = CW'(req_ch.slice_pos);
   assign avail     = total_ff - start_ext;
   assign want      = (req_ch.read_count > CNT_W'(MAX_SLICE)) ? CW'(MAX_SLICE)
                                                             : CW'(req_ch.read_count);
   assign byte_addr = hoff_ff + OFF_W'(in_off_ff);
   assign add_full  = (add_used_ff >= AU_W'(ADD_BYTES));
   assign rl_new    = add_full ? run_len_ff : run_len_ff + 1'b1;
   assign run_ext   = CW'(run_len_ff);

   always_comb begin
      cur_off = (state_ff == S_SP_CHK) ? cursor_ff - cur_ff : pos_ff - cur_ff;
      net_new = 2'(cur_off != '0) + 2'(cur_off < CW'(pr_len));
      need    = {1'b0, piece_count_ff} + (PC_W+1)'(net_new);
   end

   always_comb begin
      p_we = 1'b0;
      p_wa = '0;
      p_wd = '0;
      p_ra = i_ff[PI_W-1:0];
      a_we = 1'b0;
      o_we = 1'b0;
      a_ra = byte_addr[AA_W-1:0];
      o_ra = byte_addr[OA_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.action == ACT_LOAD && !edited_ff &&
                orig_size_ff < OS_W'(ORIG_BYTES)) begin
               o_we = 1'b1;
               p_we = 1'b1;
               p_wd = {1'b0, OFF_W'(0), LEN_W'(orig_size_ff + 1'b1)};
            end
            if (accept && req_ch.action == ACT_INSERT && !add_full) begin
               a_we = 1'b1;
            end
         end
         S_SP_APP: begin
            p_we = 1'b1;
            p_wa = piece_count_ff[PI_W-1:0];
            p_wd = {1'b1, OFF_W'(run_start_ff), LEN_W'(run_len_ff)};
         end
         S_SH_RD: begin
            p_ra = PI_W'(j_ff - 1'b1);
         end
         S_SH_WR: begin
            p_we = 1'b1;
            p_wa = PI_W'(j_ff - 1'b1 + PC_W'(net_ff));
            p_wd = p_rd;
         end
         S_PUT: begin
            p_wa = wp_ff;
            case (phase_ff)
               2'd0: begin
                  p_we = (in_off_ff != '0);
                  p_wd = {hsrc_ff, hoff_ff, in_off_ff};
               end
               2'd1: begin
                  p_we = 1'b1;
                  p_wd = {1'b1, OFF_W'(run_start_ff), LEN_W'(run_len_ff)};
               end
               default: begin
                  p_we = (in_off_ff < hlen_ff);
                  p_wd = {hsrc_ff, byte_addr, hlen_ff - in_off_ff};
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   ptts_ram #(.WIDTH(PE_W), .DEPTH(MAX_PIECES)) u_piece_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_wa),
      .wr_data (p_wd),
      .rd_addr (p_ra),
      .rd_data (p_rd)
   );

   ptts_ram #(.WIDTH(BYTE_W), .DEPTH(ADD_BYTES)) u_add_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (add_used_ff[AA_W-1:0]),
      .wr_data (req_ch.data_byte),
      .rd_addr (a_ra),
      .rd_data (a_rd)
   );

   ptts_ram #(.WIDTH(BYTE_W), .DEPTH(ORIG_BYTES)) u_orig_ram (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (orig_size_ff[OA_W-1:0]),
      .wr_data (req_ch.data_byte),
      .rd_addr (o_ra),
      .rd_data (o_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         piece_count_ff <= '0;
         add_used_ff    <= '0;
         orig_size_ff   <= '0;
         total_ff       <= '0;
         cursor_ff      <= '0;
         run_start_ff   <= '0;
         run_len_ff     <= '0;
         edited_ff      <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  out_byte_ff <= '0;
                  last_ff     <= 1'b1;
                  status_ff   <= ST_OK;
                  i_ff        <= '0;
                  cur_ff      <= '0;
                  state_ff    <= S_RESP;
                  case (req_ch.action)
                     ACT_CLEAR: begin
                        piece_count_ff <= '0;
                        add_used_ff    <= '0;
                        orig_size_ff   <= '0;
                        total_ff       <= '0;
                        cursor_ff      <= '0;
                        run_start_ff   <= '0;
                        run_len_ff     <= '0;
                        edited_ff      <= 1'b0;
                     end
                     ACT_LOAD: begin
                        if (edited_ff) begin
                           status_ff <= ST_LOAD_DENIED;
                        end else if (orig_size_ff >= OS_W'(ORIG_BYTES)) begin
                           status_ff <= ST_STORE_FULL;
                        end else begin
                           orig_size_ff   <= orig_size_ff + 1'b1;
                           total_ff       <= total_ff + 1'b1;
                           piece_count_ff <= PC_W'(1);
                        end
                     end
                     ACT_INSERT: begin
                        edited_ff <= 1'b1;
                        if (add_full) begin
                           status_ff <= ST_STORE_FULL;
                        end else begin
                           add_used_ff <= add_used_ff + 1'b1;
                           if (run_len_ff == '0) begin
                              run_start_ff <= add_used_ff[AA_W-1:0];
                           end
                        end
                        if (req_ch.end_of_run && rl_new != '0) begin
                           run_len_ff <= rl_new;
                           state_ff   <= S_SP_RD;
                        end else begin
                           run_len_ff <= req_ch.end_of_run ? '0 : rl_new;
                        end
                     end
                     default: begin
                        if (req_ch.read_count == '0 || start_ext >= total_ff) begin
                           status_ff <= ST_RANGE;
                        end else begin
                           remain_ff <= (avail < want) ? CNT_W'(avail) : CNT_W'(want);
                           pos_ff    <= start_ext;
                           state_ff  <= S_RD_FIND;
                        end
                     end
                  endcase
               end
            end
            S_RESP: begin
               if (rsp_ch.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SP_RD: begin
               if (i_ff >= piece_count_ff) begin
                  if (piece_count_ff >= PC_W'(MAX_PIECES)) begin
                     status_ff  <= ST_TABLE_FULL;
                     run_len_ff <= '0;
                     state_ff   <= S_RESP;
                  end else begin
                     state_ff <= S_SP_APP;
                  end
               end else begin
                  state_ff <= S_SP_CHK;
               end
            end
            S_SP_CHK: begin
               if (cursor_ff <= pr_next) begin
                  idx_ff    <= i_ff[PI_W-1:0];
                  wp_ff     <= i_ff[PI_W-1:0];
                  hsrc_ff   <= pr_src;
                  hoff_ff   <= pr_off;
                  hlen_ff   <= pr_len;
                  in_off_ff <= LEN_W'(cur_off);
                  net_ff    <= net_new;
                  j_ff      <= piece_count_ff;
                  phase_ff  <= 2'd0;
                  if (need > (PC_W+1)'(MAX_PIECES)) begin
                     status_ff  <= ST_TABLE_FULL;
                     run_len_ff <= '0;
                     state_ff   <= S_RESP;
                  end else if (net_new == 2'd0) begin
                     state_ff <= S_PUT;
                  end else begin
                     state_ff <= S_SH_RD;
                  end
               end else begin
                  cur_ff   <= pr_next;
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_SP_RD;
               end
            end
            S_SP_APP: begin
               piece_count_ff <= piece_count_ff + 1'b1;
               total_ff       <= total_ff + run_ext;
               cursor_ff      <= cursor_ff + run_ext;
               run_len_ff     <= '0;
               state_ff       <= S_RESP;
            end
            S_SH_RD: begin
               if (j_ff > PC_W'(idx_ff) + 1'b1) begin
                  state_ff <= S_SH_WR;
               end else begin
                  state_ff <= S_PUT;
               end
            end
            S_SH_WR: begin
               j_ff     <= j_ff - 1'b1;
               state_ff <= S_SH_RD;
            end
            S_PUT: begin
               if (p_we) begin
                  wp_ff <= wp_ff + 1'b1;
               end
               phase_ff <= phase_ff + 1'b1;
               if (phase_ff == 2'd2) begin
                  piece_count_ff <= piece_count_ff + PC_W'(net_ff);
                  total_ff       <= total_ff + run_ext;
                  cursor_ff      <= cursor_ff + run_ext;
                  run_len_ff     <= '0;
                  state_ff       <= S_RESP;
               end
            end
            S_RD_FIND: begin
               state_ff <= S_RD_FCHK;
            end
            S_RD_FCHK: begin
               if (pos_ff < pr_next) begin
                  hsrc_ff   <= pr_src;
                  hoff_ff   <= pr_off;
                  hlen_ff   <= pr_len;
                  in_off_ff <= LEN_W'(cur_off);
                  state_ff  <= S_RD_BYTE;
               end else begin
                  cur_ff   <= pr_next;
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_RD_FIND;
               end
            end
            S_RD_BYTE: begin
               state_ff <= S_RD_WAIT;
            end
            S_RD_WAIT: begin
               out_byte_ff <= hsrc_ff ? a_rd : o_rd;
               last_ff     <= (remain_ff == CNT_W'(1));
               status_ff   <= ST_OK;
               state_ff    <= S_RD_EMIT;
            end
            S_RD_EMIT: begin
               if (rsp_ch.ready) begin
                  remain_ff <= remain_ff - 1'b1;
                  pos_ff    <= pos_ff + 1'b1;
                  if (last_ff) begin
                     state_ff <= S_IDLE;
                  end else if (in_off_ff + 1'b1 == hlen_ff) begin
                     cur_ff   <= cur_ff + CW'(hlen_ff);
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_RD_FIND;
                  end else begin
                     in_off_ff <= in_off_ff + 1'b1;
                     state_ff  <= S_RD_BYTE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = (state_ff == S_RESP) || (state_ff == S_RD_EMIT);
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.last       = last_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.cursor_pos = cursor_ff[POS_W-1:0];
   assign rsp_ch.doc_length = total_ff[POS_W-1:0];

endmodule

`default_nettype wire
